/* rtl/eps_pkg.sv */
// eps_pkg: shared types and constants of the elevation palette shader
// register indexes, reset values, pipeline stage map
// no dependencies
package eps_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW = 104;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [2:0] {
    REG_SCALE_MODE    = 3'd0,
    REG_SHADE_ENABLE  = 3'd1,
    REG_LOW_LIMIT     = 3'd2,
    REG_HIGH_LIMIT    = 3'd3,
    REG_PAL_ENTRIES   = 3'd4,
    REG_AMBIENT_GAIN  = 3'd5,
    REG_DIFFUSE_GAIN  = 3'd6,
    REG_SPECULAR_GAIN = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SCALE_DIV     = 2'd0,
    SCALE_STRETCH = 2'd1,
    SCALE_LOG     = 2'd2
  } scale_mode_e;

  localparam logic [31:0] HighLimitRst = 32'd65536;
  localparam logic [8:0]  PalEntriesRst = 9'd255;
  localparam logic [15:0] AmbientRst = 16'd3277;
  localparam logic [15:0] DiffuseRst = 16'd819;
  localparam logic [15:0] SpecularRst = 16'd4096;
  localparam logic [16:0] Log10Of2Q16 = 17'd19728;
  localparam logic [16:0] QOne = 17'h10000;

  // pipeline stage map
  localparam int unsigned StIn  = 0;
  localparam int unsigned StLz  = 1;
  localparam int unsigned StSq  = 2;
  localparam int unsigned NSq   = 16;
  localparam int unsigned StLog = StSq + NSq;
  localparam int unsigned StClo = StLog + 1;
  localparam int unsigned StChi = StClo + 1;
  localparam int unsigned StNd  = StChi + 1;
  localparam int unsigned StAbs = StNd + 1;
  localparam int unsigned StQi  = StAbs + 1;
  localparam int unsigned StDv  = StQi + 1;
  localparam int unsigned NDv   = 16;
  localparam int unsigned StIdx = StDv + NDv;
  localparam int unsigned StRd  = StIdx + 1;
  localparam int unsigned StMul = StRd + 1;
  localparam int unsigned StOut = StMul + 1;
  localparam int unsigned NStg  = StOut + 1;

endpackage

/* rtl/eps_ram.sv */
// eps_ram: generic single write port ram with registered read
// no dependencies
module eps_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/elevation_palette_shader.sv */
// channel  dir  fields (lsb first)
// s_axis   in   tuser: mode | tdata: elevation, diffuse, specular, visible,
//                                    palette_index, palette_red, palette_green, palette_blue
// m_axis   out  tuser: painted | tdata: red, green, blue
// cfg      in   write enable, register index, 32 bit data
//
// one item per cycle unless the skid entry is full or the palette is clearing; 44 pipeline stages plus output register
// log10 takes 16 squaring stages, the divider 16 restoring stages, one multiplier per squaring stage
// after reset a clearing pass over all PALETTE_DEPTH entries loads the gray ramp, no item taken
// output register plus skid entry: the pipeline freezes only when the skid entry is full
// depends on eps_pkg and eps_ram
module elevation_palette_shader
  import eps_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // elevation, diffuse, specular, visible,
                                              // palette_index, red, green, blue, zero pad
  input  logic [0:0]          s_axis_tuser,   // mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // red, green, blue
  output logic [0:0]          m_axis_tuser,   // painted
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  typedef struct packed {
    logic               wr;
    logic               vis;
    logic               skip;
    logic               use_log;
    logic signed [31:0] c;
    logic signed [15:0] dif;
    logic signed [15:0] spc;
    logic [7:0]         pidx;
    logic [23:0]        prgb;
    logic signed [32:0] jp;
    logic signed [32:0] kp;
    logic signed [33:0] j;
    logic [30:0]        m;
    logic signed [21:0] l2;
    logic signed [38:0] p;
    logic signed [32:0] num;
    logic signed [32:0] den;
    logic [32:0]        nmag;
    logic [32:0]        dmag;
    logic               sdiff;
    logic               dzero;
    logic               div_on;
    logic [33:0]        rem;
    logic [16:0]        q;
    logic [AW-1:0]      idx;
    logic [23:0]        col;
    logic signed [42:0] pr_r;
    logic signed [42:0] pr_g;
    logic signed [42:0] pr_b;
    logic signed [42:0] k255;
    logic [23:0]        res;
  } pipe_t;

  // configuration
  logic [1:0]         scale_q;
  logic               shade_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;
  logic [8:0]         entries_q;
  logic [15:0]        amb_q;
  logic [15:0]        dgain_q;
  logic [15:0]        sgain_q;

  pipe_t            st_q [NStg];
  pipe_t            st_d [NStg];
  logic [NStg-1:0]  vld_q;
  logic             en;
  logic             accept;

  logic             clearing_q;
  logic [AW-1:0]    clr_cnt_q;

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [24:0]      out_q, out_d;
  logic [24:0]      skid_q, skid_d;
  logic             push;

  logic [8:0]       nm1;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [23:0]      ram_wdata;
  logic [23:0]      pal_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_DIV;
      shade_q   <= 1'b0;
      lo_q      <= '0;
      hi_q      <= HighLimitRst;
      entries_q <= PalEntriesRst;
      amb_q     <= AmbientRst;
      dgain_q   <= DiffuseRst;
      sgain_q   <= SpecularRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SCALE_MODE:    scale_q   <= cfg_data_i[1:0];
        REG_SHADE_ENABLE:  shade_q   <= cfg_data_i[0];
        REG_LOW_LIMIT:     lo_q      <= cfg_data_i;
        REG_HIGH_LIMIT:    hi_q      <= cfg_data_i;
        REG_PAL_ENTRIES:   entries_q <= cfg_data_i[8:0];
        REG_AMBIENT_GAIN:  amb_q     <= cfg_data_i[15:0];
        REG_DIFFUSE_GAIN:  dgain_q   <= cfg_data_i[15:0];
        REG_SPECULAR_GAIN: sgain_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // entries in use minus one, limited to the palette
  always_comb begin
    logic [8:0] n;
    n = (entries_q == 9'd0) ? 9'd1 : entries_q;
    if (int'(n) > int'(PALETTE_DEPTH)) begin
      n = 9'(PALETTE_DEPTH);
    end
    nm1 = n - 9'd1;
  end

  assign en = !skid_valid_q;
  assign s_axis_tready = en && !clearing_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign push = en && vld_q[NStg-1];

  always_comb begin
    logic [4:0]         msb;
    logic [61:0]        sq;
    logic [31:0]        t;
    logic signed [31:0] csel;
    logic [33:0]        r2;
    logic [25:0]        prod;
    logic [9:0]         idx10;
    logic signed [42:0] v;
    logic [7:0]         ch;
    logic [7:0]         o;

    // input stage
    st_d[StIn]         = '0;
    st_d[StIn].wr      = s_axis_tuser[0];
    st_d[StIn].c       = s_axis_tdata[31:0];
    st_d[StIn].dif     = s_axis_tdata[47:32];
    st_d[StIn].spc     = s_axis_tdata[63:48];
    st_d[StIn].vis     = s_axis_tdata[64];
    st_d[StIn].pidx    = s_axis_tdata[72:65];
    st_d[StIn].prgb    = {s_axis_tdata[80:73], s_axis_tdata[88:81], s_axis_tdata[96:89]};
    for (int i = 1; i < NStg; i++) begin
      st_d[i] = st_q[i-1];
    end

    // leading one, mantissa, shading products
    msb = '0;
    for (int b = 0; b < 31; b++) begin
      if (st_q[StIn].c[b]) begin
        msb = 5'(b);
      end
    end
    st_d[StLz].use_log = (scale_q == SCALE_LOG) && (st_q[StIn].c > 0);
    st_d[StLz].m  = 31'(st_q[StIn].c[30:0] << (5'd30 - msb));
    st_d[StLz].l2 = $signed({6'({1'b0, msb}) - 6'd16, 16'h0000});
    st_d[StLz].jp = $signed({1'b0, dgain_q}) * st_q[StIn].dif;
    st_d[StLz].kp = $signed({1'b0, sgain_q}) * st_q[StIn].spc;

    // log2 fraction, one squaring per stage
    for (int r = 0; r < NSq; r++) begin
      sq = 62'(st_q[StSq+r-1].m) * 62'(st_q[StSq+r-1].m);
      t  = sq[61:30];
      if (t[31]) begin
        st_d[StSq+r].m = t[31:1];
        st_d[StSq+r].l2[NSq-1-r] = 1'b1;
      end else begin
        st_d[StSq+r].m = t[30:0];
      end
    end

    // log10 product, diffuse sum
    st_d[StLog].p = st_q[StLog-1].l2 * $signed(Log10Of2Q16);
    st_d[StLog].j = $signed({4'b0000, amb_q, 14'h0000}) + 34'(st_q[StLog-1].jp);

    // value select and low clamp
    csel = st_q[StClo-1].use_log ? 32'($signed(st_q[StClo-1].p[38:16])) : st_q[StClo-1].c;
    st_d[StClo].skip = st_q[StClo-1].wr || !st_q[StClo-1].vis || (csel < 0);
    st_d[StClo].c    = (csel < lo_q) ? lo_q : csel;

    // high clamp
    st_d[StChi].c = (st_q[StChi-1].c > hi_q) ? hi_q : st_q[StChi-1].c;

    // numerator and divisor
    if (scale_q == SCALE_DIV) begin
      st_d[StNd].num = 33'(st_q[StNd-1].c);
      st_d[StNd].den = 33'(hi_q);
    end else begin
      st_d[StNd].num = 33'(st_q[StNd-1].c) - 33'(lo_q);
      st_d[StNd].den = 33'(hi_q) - 33'(lo_q);
    end

    // magnitudes and signs
    st_d[StAbs].nmag  = st_q[StAbs-1].num[32] ? 33'(-st_q[StAbs-1].num)
                                              : 33'(st_q[StAbs-1].num);
    st_d[StAbs].dmag  = st_q[StAbs-1].den[32] ? 33'(-st_q[StAbs-1].den)
                                              : 33'(st_q[StAbs-1].den);
    st_d[StAbs].sdiff = st_q[StAbs-1].num[32] != st_q[StAbs-1].den[32];
    st_d[StAbs].dzero = st_q[StAbs-1].den == '0;

    // quotient cases
    st_d[StQi].div_on = 1'b0;
    st_d[StQi].rem    = 34'(st_q[StQi-1].nmag);
    if (st_q[StQi-1].dzero) begin
      st_d[StQi].q = QOne;
    end else if (st_q[StQi-1].sdiff) begin
      st_d[StQi].q = '0;
    end else if (st_q[StQi-1].nmag >= st_q[StQi-1].dmag) begin
      st_d[StQi].q = QOne;
    end else begin
      st_d[StQi].q      = '0;
      st_d[StQi].div_on = 1'b1;
    end

    // restoring division, one quotient bit per stage
    for (int d = 0; d < NDv; d++) begin
      r2 = {st_q[StDv+d-1].rem[32:0], 1'b0};
      if (st_q[StDv+d-1].div_on) begin
        if (r2 >= {1'b0, st_q[StDv+d-1].dmag}) begin
          st_d[StDv+d].rem = r2 - {1'b0, st_q[StDv+d-1].dmag};
          st_d[StDv+d].q   = {st_q[StDv+d-1].q[15:0], 1'b1};
        end else begin
          st_d[StDv+d].rem = r2;
          st_d[StDv+d].q   = {st_q[StDv+d-1].q[15:0], 1'b0};
        end
      end
    end

    // palette index
    prod  = 26'(nm1) * 26'(st_q[StIdx-1].q);
    idx10 = prod[25:16];
    st_d[StIdx].idx = (int'(idx10) > int'(PALETTE_DEPTH) - 1) ? AW'(PALETTE_DEPTH - 1)
                                                              : AW'(idx10);

    // shading products
    st_d[StMul].col  = pal_rdata;
    st_d[StMul].pr_r = $signed({1'b0, pal_rdata[23:16]}) * st_q[StMul-1].j;
    st_d[StMul].pr_g = $signed({1'b0, pal_rdata[15:8]}) * st_q[StMul-1].j;
    st_d[StMul].pr_b = $signed({1'b0, pal_rdata[7:0]}) * st_q[StMul-1].j;
    st_d[StMul].k255 = (43'(st_q[StMul-1].kp) <<< 8) - 43'(st_q[StMul-1].kp);

    // sum and saturate, palette colour when shading is off, zero when skipped
    for (int k = 0; k < 3; k++) begin
      case (k)
        0:       v = st_q[StOut-1].pr_b + st_q[StOut-1].k255;
        1:       v = st_q[StOut-1].pr_g + st_q[StOut-1].k255;
        default: v = st_q[StOut-1].pr_r + st_q[StOut-1].k255;
      endcase
      ch = st_q[StOut-1].col[8*k +: 8];
      if (!shade_q) begin
        o = ch;
      end else if (v < 0) begin
        o = 8'd0;
      end else if (v[42:26] > 17'd255) begin
        o = 8'd255;
      end else begin
        o = v[33:26];
      end
      st_d[StOut].res[8*k +: 8] = st_q[StOut-1].skip ? 8'd0 : o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NStg; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], accept};
    end
  end

  // palette clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(PALETTE_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = {3{8'(clr_cnt_q)}};
    end else begin
      ram_we    = en && vld_q[StIdx] && st_q[StIdx].wr
                  && (int'(st_q[StIdx].pidx) < int'(PALETTE_DEPTH));
      ram_waddr = AW'(st_q[StIdx].pidx);
      ram_wdata = st_q[StIdx].prgb;
    end
  end

  eps_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (en && vld_q[StIdx]),
    .raddr_i(st_q[StIdx].idx),
    .rdata_o(pal_rdata)
  );

  // output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d = {!st_q[NStg-1].skip, st_q[NStg-1].res};
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_d       = {!st_q[NStg-1].skip, st_q[NStg-1].res};
        out_valid_d = 1'b1;
      end else begin
        skid_d       = {!st_q[NStg-1].skip, st_q[NStg-1].res};
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[7:0], out_q[15:8], out_q[23:16]};
  assign m_axis_tuser  = out_q[24];

  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready)
    else $error("item taken during palette clear");

  a_clear_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (vld_q == '0) && !out_valid_q)
    else $error("pipeline busy during palette clear");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds an item ahead of the output register");

endmodule
